FILE: rtl/core/skf_pkg.sv
`default_nettype none
package skf_pkg;

  localparam int WORD_W        = 32;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int STATE_DIM_DEF = 2;
  localparam int FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_F_ROW0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_F_ROW1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H_ROW       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Q_DIAG      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Q_OFF_AND_R = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_P_INIT_DIAG = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_P_INIT_OFF  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_X_INIT      = 3'd7;

  localparam logic [CFG_W-1:0]  RST_F_ROW0      = 64'd281474976710656;
  localparam logic [CFG_W-1:0]  RST_F_ROW1      = 64'd65536;
  localparam logic [CFG_W-1:0]  RST_H_ROW       = 64'd281474976710656;
  localparam logic [CFG_W-1:0]  RST_Q_DIAG      = 64'd0;
  localparam logic [CFG_W-1:0]  RST_Q_OFF_AND_R = 64'd65536;
  localparam logic [CFG_W-1:0]  RST_P_INIT_DIAG = 64'd281479271743488;
  localparam logic [WORD_W-1:0] RST_P_INIT_OFF  = 32'd0;
  localparam logic [CFG_W-1:0]  RST_X_INIT      = 64'd0;

  typedef struct packed {
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    logic signed [WORD_W-1:0] base;
    logic                     sub;
  } mac_op_t;

  typedef struct packed {
    logic                     start;
    logic signed [WORD_W-1:0] num;
    logic signed [WORD_W-1:0] den;
  } div_req_t;

endpackage
`default_nettype wire

FILE: rtl/core/skf_if.sv
`default_nettype none
interface skf_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [skf_pkg::WORD_W-1:0] measurement;
  logic                             restart;
  modport source (output valid, output measurement, output restart, input ready);
  modport sink (input valid, input measurement, input restart, output ready);
endinterface

interface skf_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [skf_pkg::WORD_W-1:0] estimate_first;
  logic signed [skf_pkg::WORD_W-1:0] estimate_second;
  logic                             gain_fault;
  modport source (output valid, output estimate_first, output estimate_second,
                  output gain_fault, input ready);
  modport sink (input valid, input estimate_first, input estimate_second,
                input gain_fault, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/skf_mac.sv
`default_nettype none
// Multiply, round, saturate and add. Stage one registers the raw
// product; stage two rounds it and folds it into the base value.
module skf_mac #(
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  wire                                clk,
  input  skf_pkg::mac_op_t                   op,
  output logic signed [skf_pkg::WORD_W-1:0]  result
);
  localparam int W = skf_pkg::WORD_W;

  logic signed [2*W-1:0] prod_r;
  logic signed [2*W-1:0] rnd;
  logic signed [2*W-1:0] shf;
  logic signed [W-1:0]   prod_sat;
  logic signed [W+1:0]   sum;

  always_ff @(posedge clk) begin
    prod_r <= op.a * op.b;
  end

  always_comb begin
    rnd = prod_r + (64'sd1 <<< (FRAC_BITS - 1));
    shf = rnd >>> FRAC_BITS;
    if (shf > 64'sh7FFFFFFF) begin
      prod_sat = 32'sh7FFFFFFF;
    end else if (shf < -64'sh80000000) begin
      prod_sat = 32'sh80000000;
    end else begin
      prod_sat = shf[W-1:0];
    end
    if (op.sub) begin
      sum = (W+2)'(op.base) - (W+2)'(prod_sat);
    end else begin
      sum = (W+2)'(op.base) + (W+2)'(prod_sat);
    end
    if (sum > 34'sh07FFFFFFF) begin
      result = 32'sh7FFFFFFF;
    end else if (sum < -34'sh080000000) begin
      result = 32'sh80000000;
    end else begin
      result = sum[W-1:0];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/skf_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle: round(num * 2^F / den),
// ties away from zero, den > 0, saturated to 32 bits.
module skf_div #(
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  skf_pkg::div_req_t                  req,
  output logic                               busy,
  output logic                               done,
  output logic signed [skf_pkg::WORD_W-1:0]  quo
);
  localparam int W   = skf_pkg::WORD_W;
  localparam int NW  = W + 1 + FRAC_BITS;
  localparam int CW  = $clog2(NW);
  localparam logic [CW-1:0] LAST = CW'(NW - 1);

  logic [NW-1:0] dvd_r;
  logic [NW-1:0] quo_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic          neg_r;

  logic [W:0]    mag;
  logic [NW-1:0] dvd_init;
  logic [W:0]    trial;
  logic          fits;
  logic [NW-1:0] clamp;

  always_comb begin
    mag      = req.num[W-1] ? -(W+1)'(req.num) : (W+1)'(req.num);
    dvd_init = (NW'(mag) << FRAC_BITS) + NW'(req.den[W-1:1]);
    trial    = {rem_r, dvd_r[NW-1]};
    fits     = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= dvd_init;
      rem_r <= '0;
      quo_r <= '0;
      den_r <= req.den;
      neg_r <= req.num[W-1];
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      quo_r <= {quo_r[NW-2:0], fits};
      rem_r <= fits ? W'(trial - {1'b0, den_r}) : trial[W-1:0];
    end
  end

  always_comb begin
    clamp = (quo_r > (NW'(1) << (W - 1))) ? (NW'(1) << (W - 1)) : quo_r;
    if (neg_r) begin
      quo = -(clamp[W-1:0]);
    end else if (clamp[W-1]) begin
      quo = 32'sh7FFFFFFF;
    end else begin
      quo = clamp[W-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;

  ap_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(busy_r))
    else $error("divider done without a running division");
  ap_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");
  ap_busy_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !busy_r)
    else $error("divider done and busy together");
endmodule
`default_nettype wire

FILE: rtl/core/scalar_kalman_filter_unit.sv
`default_nettype none
// Channel   | Dir | Payload                                          | Transfer
// in_ch     | in  | measurement[31:0] signed, restart                | valid & ready
// out_ch    | out | estimate_first, estimate_second, gain_fault      | valid & ready
// cfg_*     | in  | cfg_index[2:0], cfg_data[63:0]                   | cfg_we
//
// An item passes from transfer through the idle state, 47 micro-ops on the shared
// multiply-accumulate unit with two serial divisions for the gain after the S op,
// and the commit state; a faulting step skips the divisions and the update ops.
// Reset is synchronous, active low, and loads the register defaults and a zero
// state. in_ch.ready is high only while the sequencer is idle; a finished result
// waits in the output register and a stalled out_ch holds the next commit until
// it frees.
module scalar_kalman_filter_unit #(
  parameter int STATE_DIM = skf_pkg::STATE_DIM_DEF,
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  skf_in_if.sink                               in_ch,
  skf_out_if.source                            out_ch,
  input  wire                                  cfg_we,
  input  wire [skf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [skf_pkg::CFG_W-1:0]             cfg_data
);
  localparam int W = skf_pkg::WORD_W;
  localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;
  localparam bit DIM2 = (STATE_DIM >= 2);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULA = 3'd1;
  localparam logic [2:0] S_MULB = 3'd2;
  localparam logic [2:0] S_DIV0 = 3'd3;
  localparam logic [2:0] S_DIV1 = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // micro-op landmarks
  localparam logic [5:0] OP_S    = 6'd32;
  localparam logic [5:0] OP_LAST = 6'd46;

  // base selects
  localparam logic [2:0] B_ZERO = 3'd0;
  localparam logic [2:0] B_ACC  = 3'd1;
  localparam logic [2:0] B_Z    = 3'd2;
  localparam logic [2:0] B_XA0  = 3'd3;
  localparam logic [2:0] B_XA1  = 3'd4;
  localparam logic [2:0] B_ONE  = 3'd5;

  // destinations
  localparam logic [4:0] D_ACC  = 5'd0;
  localparam logic [4:0] D_XA0  = 5'd1;
  localparam logic [4:0] D_XA1  = 5'd2;
  localparam logic [4:0] D_T00  = 5'd3;
  localparam logic [4:0] D_T01  = 5'd4;
  localparam logic [4:0] D_T10  = 5'd5;
  localparam logic [4:0] D_T11  = 5'd6;
  localparam logic [4:0] D_PP00 = 5'd7;
  localparam logic [4:0] D_PP01 = 5'd8;
  localparam logic [4:0] D_PP10 = 5'd9;
  localparam logic [4:0] D_PP11 = 5'd10;
  localparam logic [4:0] D_Y    = 5'd11;
  localparam logic [4:0] D_PH0  = 5'd12;
  localparam logic [4:0] D_PH1  = 5'd13;
  localparam logic [4:0] D_S    = 5'd14;
  localparam logic [4:0] D_I00  = 5'd15;
  localparam logic [4:0] D_I01  = 5'd16;
  localparam logic [4:0] D_I10  = 5'd17;
  localparam logic [4:0] D_I11  = 5'd18;
  localparam logic [4:0] D_PN00 = 5'd19;
  localparam logic [4:0] D_PN01 = 5'd20;
  localparam logic [4:0] D_PN10 = 5'd21;
  localparam logic [4:0] D_PN11 = 5'd22;

  // configuration registers
  logic [skf_pkg::CFG_W-1:0] f_row0_r, f_row1_r, h_row_r, q_diag_r, q_off_and_r_r;
  logic [skf_pkg::CFG_W-1:0] p_init_diag_r, x_init_r;
  logic [W-1:0]              p_init_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_row0_r      <= skf_pkg::RST_F_ROW0;
      f_row1_r      <= skf_pkg::RST_F_ROW1;
      h_row_r       <= skf_pkg::RST_H_ROW;
      q_diag_r      <= skf_pkg::RST_Q_DIAG;
      q_off_and_r_r <= skf_pkg::RST_Q_OFF_AND_R;
      p_init_diag_r <= skf_pkg::RST_P_INIT_DIAG;
      p_init_off_r  <= skf_pkg::RST_P_INIT_OFF;
      x_init_r      <= skf_pkg::RST_X_INIT;
    end else if (cfg_we) begin
      case (cfg_index)
        skf_pkg::REG_F_ROW0:      f_row0_r      <= cfg_data;
        skf_pkg::REG_F_ROW1:      f_row1_r      <= cfg_data;
        skf_pkg::REG_H_ROW:       h_row_r       <= cfg_data;
        skf_pkg::REG_Q_DIAG:      q_diag_r      <= cfg_data;
        skf_pkg::REG_Q_OFF_AND_R: q_off_and_r_r <= cfg_data;
        skf_pkg::REG_P_INIT_DIAG: p_init_diag_r <= cfg_data;
        skf_pkg::REG_P_INIT_OFF:  p_init_off_r  <= cfg_data[W-1:0];
        skf_pkg::REG_X_INIT:      x_init_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Matrix entries; with a single state the cross and second-state terms of F
  // and H read as zero, which leaves entry zero exactly as the scalar filter.
  logic signed [W-1:0] f00, f01, f10, f11, h0, h1, q00, q01, q11, r_val;
  assign f00   = f_row0_r[2*W-1:W];
  assign f01   = DIM2 ? f_row0_r[W-1:0] : '0;
  assign f10   = DIM2 ? f_row1_r[2*W-1:W] : '0;
  assign f11   = DIM2 ? f_row1_r[W-1:0] : '0;
  assign h0    = h_row_r[2*W-1:W];
  assign h1    = DIM2 ? h_row_r[W-1:0] : '0;
  assign q00   = q_diag_r[2*W-1:W];
  assign q11   = q_diag_r[W-1:0];
  assign q01   = q_off_and_r_r[2*W-1:W];
  assign r_val = q_off_and_r_r[W-1:0];

  // state and working registers
  logic signed [W-1:0] sv0_r, sv1_r, cv00_r, cv01_r, cv10_r, cv11_r;
  logic signed [W-1:0] z_r, acc_r, xa0_r, xa1_r;
  logic signed [W-1:0] t00_r, t01_r, t10_r, t11_r;
  logic signed [W-1:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic signed [W-1:0] y_r, ph0_r, ph1_r, s_r, k0_r, k1_r;
  logic signed [W-1:0] i00_r, i01_r, i10_r, i11_r;
  logic signed [W-1:0] pn00_r, pn01_r, pn10_r, pn11_r;

  logic [2:0] state_r, state_nxt;
  logic [5:0] op_r, op_nxt;
  logic       fault_r, fault_nxt;

  logic signed [W-1:0] est0_r, est1_r;
  logic                out_fault_r;
  logic                out_valid_r;

  logic                in_xfer;
  logic                out_free;
  logic                commit;

  skf_pkg::mac_op_t    mop;
  logic signed [W-1:0] mac_res;
  logic [2:0]          base_sel;
  logic [4:0]          dest;

  skf_pkg::div_req_t   dreq;
  logic                div_busy;
  logic                div_done;
  logic signed [W-1:0] div_quo;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign commit   = (state_r == S_DONE) && out_free;

  // micro-op table: operands, base, sign and destination
  always_comb begin
    mop.a    = '0;
    mop.b    = '0;
    mop.sub  = 1'b0;
    base_sel = B_ZERO;
    dest     = D_ACC;
    case (op_r)
      // predicted state
      6'd0:  begin mop.a = f00; mop.b = sv0_r; end
      6'd1:  begin mop.a = f01; mop.b = sv1_r; base_sel = B_ACC; dest = D_XA0; end
      6'd2:  begin mop.a = f10; mop.b = sv0_r; end
      6'd3:  begin mop.a = f11; mop.b = sv1_r; base_sel = B_ACC; dest = D_XA1; end
      // T = F P
      6'd4:  begin mop.a = f00; mop.b = cv00_r; end
      6'd5:  begin mop.a = f01; mop.b = cv10_r; base_sel = B_ACC; dest = D_T00; end
      6'd6:  begin mop.a = f00; mop.b = cv01_r; end
      6'd7:  begin mop.a = f01; mop.b = cv11_r; base_sel = B_ACC; dest = D_T01; end
      6'd8:  begin mop.a = f10; mop.b = cv00_r; end
      6'd9:  begin mop.a = f11; mop.b = cv10_r; base_sel = B_ACC; dest = D_T10; end
      6'd10: begin mop.a = f10; mop.b = cv01_r; end
      6'd11: begin mop.a = f11; mop.b = cv11_r; base_sel = B_ACC; dest = D_T11; end
      // P = T F' + Q; the noise term enters as a product with one
      6'd12: begin mop.a = t00_r; mop.b = f00; end
      6'd13: begin mop.a = t01_r; mop.b = f01; base_sel = B_ACC; end
      6'd14: begin mop.a = q00; mop.b = ONE; base_sel = B_ACC; dest = D_PP00; end
      6'd15: begin mop.a = t00_r; mop.b = f10; end
      6'd16: begin mop.a = t01_r; mop.b = f11; base_sel = B_ACC; end
      6'd17: begin mop.a = q01; mop.b = ONE; base_sel = B_ACC; dest = D_PP01; end
      6'd18: begin mop.a = t10_r; mop.b = f00; end
      6'd19: begin mop.a = t11_r; mop.b = f01; base_sel = B_ACC; end
      6'd20: begin mop.a = q01; mop.b = ONE; base_sel = B_ACC; dest = D_PP10; end
      6'd21: begin mop.a = t10_r; mop.b = f10; end
      6'd22: begin mop.a = t11_r; mop.b = f11; base_sel = B_ACC; end
      6'd23: begin mop.a = q11; mop.b = ONE; base_sel = B_ACC; dest = D_PP11; end
      // innovation
      6'd24: begin mop.a = h0; mop.b = xa0_r; base_sel = B_Z; mop.sub = 1'b1; end
      6'd25: begin
        mop.a = h1; mop.b = xa1_r; base_sel = B_ACC; mop.sub = 1'b1; dest = D_Y;
      end
      // P H'
      6'd26: begin mop.a = pp00_r; mop.b = h0; end
      6'd27: begin mop.a = pp01_r; mop.b = h1; base_sel = B_ACC; dest = D_PH0; end
      6'd28: begin mop.a = pp10_r; mop.b = h0; end
      6'd29: begin mop.a = pp11_r; mop.b = h1; base_sel = B_ACC; dest = D_PH1; end
      // S = H P H' + R
      6'd30: begin mop.a = h0; mop.b = ph0_r; end
      6'd31: begin mop.a = h1; mop.b = ph1_r; base_sel = B_ACC; end
      6'd32: begin mop.a = r_val; mop.b = ONE; base_sel = B_ACC; dest = D_S; end
      // state update
      6'd33: begin mop.a = k0_r; mop.b = y_r; base_sel = B_XA0; dest = D_XA0; end
      6'd34: begin mop.a = k1_r; mop.b = y_r; base_sel = B_XA1; dest = D_XA1; end
      // I - K H
      6'd35: begin mop.a = k0_r; mop.b = h0; base_sel = B_ONE; mop.sub = 1'b1; dest = D_I00; end
      6'd36: begin mop.a = k0_r; mop.b = h1; mop.sub = 1'b1; dest = D_I01; end
      6'd37: begin mop.a = k1_r; mop.b = h0; mop.sub = 1'b1; dest = D_I10; end
      6'd38: begin mop.a = k1_r; mop.b = h1; base_sel = B_ONE; mop.sub = 1'b1; dest = D_I11; end
      // (I - K H) P
      6'd39: begin mop.a = i00_r; mop.b = pp00_r; end
      6'd40: begin mop.a = i01_r; mop.b = pp10_r; base_sel = B_ACC; dest = D_PN00; end
      6'd41: begin mop.a = i00_r; mop.b = pp01_r; end
      6'd42: begin mop.a = i01_r; mop.b = pp11_r; base_sel = B_ACC; dest = D_PN01; end
      6'd43: begin mop.a = i10_r; mop.b = pp00_r; end
      6'd44: begin mop.a = i11_r; mop.b = pp10_r; base_sel = B_ACC; dest = D_PN10; end
      6'd45: begin mop.a = i10_r; mop.b = pp01_r; end
      6'd46: begin mop.a = i11_r; mop.b = pp11_r; base_sel = B_ACC; dest = D_PN11; end
      default: ;
    endcase
    case (base_sel)
      B_ACC:   mop.base = acc_r;
      B_Z:     mop.base = z_r;
      B_XA0:   mop.base = xa0_r;
      B_XA1:   mop.base = xa1_r;
      B_ONE:   mop.base = ONE;
      default: mop.base = '0;
    endcase
  end

  skf_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk    (clk),
    .op     (mop),
    .result (mac_res)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    fault_nxt  = fault_r;
    dreq.start = 1'b0;
    dreq.num   = ph0_r;
    dreq.den   = s_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_MULA;
          op_nxt    = '0;
          fault_nxt = 1'b0;
        end
      end
      S_MULA: state_nxt = S_MULB;
      S_MULB: begin
        if (op_r == OP_S) begin
          // skip the update when S is not positive
          if (mac_res[W-1] || mac_res == '0) begin
            fault_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            dreq.start = 1'b1;
            dreq.den   = mac_res;
            state_nxt  = S_DIV0;
          end
        end else if (op_r == OP_LAST) begin
          state_nxt = S_DONE;
        end else begin
          op_nxt    = op_r + 1'b1;
          state_nxt = S_MULA;
        end
      end
      S_DIV0: begin
        if (div_done) begin
          dreq.start = 1'b1;
          dreq.num   = ph1_r;
          state_nxt  = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          op_nxt    = OP_S + 1'b1;
          state_nxt = S_MULA;
        end
      end
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  skf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      fault_r <= fault_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // filter state: reload on restart, write back on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv0_r  <= '0;
      sv1_r  <= '0;
      cv00_r <= '0;
      cv01_r <= '0;
      cv10_r <= '0;
      cv11_r <= '0;
    end else if (in_xfer && in_ch.restart) begin
      sv0_r  <= x_init_r[2*W-1:W];
      sv1_r  <= x_init_r[W-1:0];
      cv00_r <= p_init_diag_r[2*W-1:W];
      cv11_r <= p_init_diag_r[W-1:0];
      cv01_r <= p_init_off_r;
      cv10_r <= p_init_off_r;
    end else if (commit) begin
      sv0_r  <= xa0_r;
      cv00_r <= fault_r ? pp00_r : pn00_r;
      if (DIM2) begin
        sv1_r  <= xa1_r;
        cv01_r <= fault_r ? pp01_r : pn01_r;
        cv10_r <= fault_r ? pp10_r : pn10_r;
        cv11_r <= fault_r ? pp11_r : pn11_r;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      z_r <= in_ch.measurement;
    end
    if (state_r == S_DIV0 && div_done) begin
      k0_r <= div_quo;
    end
    if (state_r == S_DIV1 && div_done) begin
      k1_r <= div_quo;
    end
    if (state_r == S_MULB) begin
      acc_r <= mac_res;
      case (dest)
        D_XA0:  xa0_r  <= mac_res;
        D_XA1:  xa1_r  <= mac_res;
        D_T00:  t00_r  <= mac_res;
        D_T01:  t01_r  <= mac_res;
        D_T10:  t10_r  <= mac_res;
        D_T11:  t11_r  <= mac_res;
        D_PP00: pp00_r <= mac_res;
        D_PP01: pp01_r <= mac_res;
        D_PP10: pp10_r <= mac_res;
        D_PP11: pp11_r <= mac_res;
        D_Y:    y_r    <= mac_res;
        D_PH0:  ph0_r  <= mac_res;
        D_PH1:  ph1_r  <= mac_res;
        D_S:    s_r    <= mac_res;
        D_I00:  i00_r  <= mac_res;
        D_I01:  i01_r  <= mac_res;
        D_I10:  i10_r  <= mac_res;
        D_I11:  i11_r  <= mac_res;
        D_PN00: pn00_r <= mac_res;
        D_PN01: pn01_r <= mac_res;
        D_PN10: pn10_r <= mac_res;
        D_PN11: pn11_r <= mac_res;
        default: ;
      endcase
    end
    // hold the result until the sink takes it
    if (commit) begin
      est0_r      <= xa0_r;
      est1_r      <= DIM2 ? xa1_r : '0;
      out_fault_r <= fault_r;
    end
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.estimate_first  = est0_r;
  assign out_ch.estimate_second = est1_r;
  assign out_ch.gain_fault      = out_fault_r;

  ap_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_MULA && op_r == '0))
    else $error("accepted item did not start the sequence");
  ap_div_in_div_states: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV0 || state_r == S_DIV1))
    else $error("divider running outside the gain phase");
  ap_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised without a commit");
  ap_fault_skips_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && fault_r) |-> op_r == OP_S)
    else $error("faulting step ran update ops");
endmodule
`default_nettype wire

FILE: bench/skf_bench_if.sv
`timescale 1ns / 100ps
package skf_bench_pkg;

  typedef struct {
    logic signed [31:0] first;
    logic signed [31:0] second;
    logic               fault;
  } estimate_t;

  class estimate_board;
    estimate_t pending[$];
    int        errors;
    int        checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    // note an accepted measurement's predicted estimate
    function void note(estimate_t e);
      pending.push_back(e);
    endfunction

    // compare one transfer from the result channel against the oldest prediction
    task check(logic signed [31:0] first, logic signed [31:0] second,
               logic fault);
      estimate_t e;
      if (pending.size() == 0) begin
        report_err($sformatf("unexpected result %h %h %b", first, second, fault));
        return;
      end
      e = pending.pop_front();
      checked++;
      if (first !== e.first)
        report_err($sformatf("estimate_first %h, want %h", first, e.first));
      if (second !== e.second)
        report_err($sformatf("estimate_second %h, want %h", second, e.second));
      if (fault !== e.fault)
        report_err($sformatf("gain_fault %b, want %b", fault, e.fault));
    endtask

    task report_err(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask
  endclass

endpackage

FILE: bench/scalar_kalman_filter_unit_tb.sv
`timescale 1ns / 100ps
module scalar_kalman_filter_unit_tb;

  localparam int FB = skf_pkg::FRAC_BITS_DEF;
  localparam longint CYCLE_LIMIT = 64'd4_000_000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [skf_pkg::CFG_W-1:0] cfg_data;

  skf_in_if  in_ch ();
  skf_out_if out_ch ();

  scalar_kalman_filter_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  skf_bench_pkg::estimate_board board;

  // Predictor copy of the configuration registers and filter state.
  logic [63:0] f0_reg, f1_reg, h_reg, qd_reg, qr_reg, pd_reg, x0_reg;
  logic [31:0] po_reg;
  int sv[2];
  int cov[4];

  bit    calm;          // last phase: no idling on either side
  longint cycles;
  int    sent, faults, restarts;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Guard against a hang: fail hard after a generous number of cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("scalar_kalman_filter_unit_tb failed");
      $finish;
    end
  end

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int qadd(int a, int b);
    return sat(longint'(a) + longint'(b));
  endfunction

  function automatic int qsub(int a, int b);
    return sat(longint'(a) - longint'(b));
  endfunction

  // Fixed-point product: round half up, then arithmetic shift and saturate.
  function automatic int qmul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b) + (64'sd1 <<< (FB - 1));
    return sat(p >>> FB);
  endfunction

  // Gain quotient for a positive divisor, rounded half away from zero.
  function automatic int qdiv(int num, int den);
    logic [63:0] n, q;
    bit neg;
    neg = num < 0;
    n = (neg ? -longint'(num) : longint'(num)) << FB;
    q = (n + (den / 2)) / den;
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return sat(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic int top(logic [63:0] v);
    return int'(v[63:32]);
  endfunction

  function automatic int bot(logic [63:0] v);
    return int'(v[31:0]);
  endfunction

  // Advance the filter state by one measurement and return the estimate.
  function automatic skf_bench_pkg::estimate_t kalman_step(int z, bit restart);
    int f[2][2], q[2][2], p[2][2], t[2][2], ikh[2][2], pn[2][2];
    int h[2], x[2], xp[2], ph[2], k[2];
    int r, y, s, acc;
    skf_bench_pkg::estimate_t e;
    if (restart) begin
      sv[0] = top(x0_reg); sv[1] = bot(x0_reg);
      cov[0] = top(pd_reg); cov[3] = bot(pd_reg);
      cov[1] = int'(po_reg); cov[2] = int'(po_reg);
    end
    f[0][0] = top(f0_reg); f[0][1] = bot(f0_reg);
    f[1][0] = top(f1_reg); f[1][1] = bot(f1_reg);
    h[0] = top(h_reg); h[1] = bot(h_reg);
    q[0][0] = top(qd_reg); q[1][1] = bot(qd_reg);
    q[0][1] = top(qr_reg); q[1][0] = q[0][1];
    r = bot(qr_reg);
    for (int i = 0; i < 2; i++) begin
      x[i] = sv[i];
      for (int j = 0; j < 2; j++) p[i][j] = cov[i*2+j];
    end
    // predict state and covariance
    for (int i = 0; i < 2; i++) begin
      xp[i] = 0;
      for (int j = 0; j < 2; j++) xp[i] = qadd(xp[i], qmul(f[i][j], x[j]));
    end
    x = xp;
    for (int i = 0; i < 2; i++)
      for (int c = 0; c < 2; c++) begin
        t[i][c] = 0;
        for (int j = 0; j < 2; j++) t[i][c] = qadd(t[i][c], qmul(f[i][j], p[j][c]));
      end
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        acc = 0;
        for (int c = 0; c < 2; c++) acc = qadd(acc, qmul(t[i][c], f[j][c]));
        p[i][j] = qadd(acc, q[i][j]);
      end
    // innovation and its variance
    y = z;
    for (int i = 0; i < 2; i++) y = qsub(y, qmul(h[i], x[i]));
    for (int i = 0; i < 2; i++) begin
      ph[i] = 0;
      for (int j = 0; j < 2; j++) ph[i] = qadd(ph[i], qmul(p[i][j], h[j]));
    end
    acc = 0;
    for (int i = 0; i < 2; i++) acc = qadd(acc, qmul(h[i], ph[i]));
    s = qadd(acc, r);
    e.fault = (s <= 0);
    // skip the correction when the variance is not positive
    if (!e.fault) begin
      for (int i = 0; i < 2; i++) k[i] = qdiv(ph[i], s);
      for (int i = 0; i < 2; i++) x[i] = qadd(x[i], qmul(k[i], y));
      for (int i = 0; i < 2; i++)
        for (int c = 0; c < 2; c++)
          ikh[i][c] = qsub((i == c) ? (1 << FB) : 0, qmul(k[i], h[c]));
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++) begin
          pn[i][j] = 0;
          for (int c = 0; c < 2; c++) pn[i][j] = qadd(pn[i][j], qmul(ikh[i][c], p[c][j]));
        end
      p = pn;
    end
    for (int i = 0; i < 2; i++) begin
      sv[i] = x[i];
      for (int j = 0; j < 2; j++) cov[i*2+j] = p[i][j];
    end
    e.first = sv[0];
    e.second = sv[1];
    return e;
  endfunction

  // Write one register on the next rising edge and mirror it in the predictor.
  task automatic write_reg(logic [skf_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      skf_pkg::REG_F_ROW0:      f0_reg = val;
      skf_pkg::REG_F_ROW1:      f1_reg = val;
      skf_pkg::REG_H_ROW:       h_reg = val;
      skf_pkg::REG_Q_DIAG:      qd_reg = val;
      skf_pkg::REG_Q_OFF_AND_R: qr_reg = val;
      skf_pkg::REG_P_INIT_DIAG: pd_reg = val;
      skf_pkg::REG_P_INIT_OFF:  po_reg = val[31:0];
      skf_pkg::REG_X_INIT:      x0_reg = val;
      default: ;
    endcase
  endtask

  // Drop valid, hold until every predicted estimate has been checked, then settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // Present one measurement, with an optional random gap first; hold until transfer.
  task automatic send(int z, bit restart);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.measurement <= z;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    board.note(kalman_step(z, restart));
    sent++;
    if (restart) restarts++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] small_q(int lim);
    return $urandom_range(0, 2*lim) - lim;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return small_q(32'h0008_0000);
    endcase
  endfunction

  // Pick a well-behaved setting most of the time, extremes now and then.
  task automatic random_setting(bit wild);
    if (wild) begin
      for (int i = 0; i < 8; i++) write_reg(i[2:0], {rand_word(), rand_word()});
    end else begin
      write_reg(skf_pkg::REG_F_ROW0, {32'h0001_0000 + small_q(4096), small_q(32'h4000)});
      write_reg(skf_pkg::REG_F_ROW1,
                {small_q(4096), 32'h0001_0000 - $urandom_range(0, 8192)});
      write_reg(skf_pkg::REG_H_ROW, {32'h0001_0000 + small_q(16384), small_q(16384)});
      write_reg(skf_pkg::REG_Q_DIAG,
                {32'($urandom_range(0, 4096)), 32'($urandom_range(0, 4096))});
      write_reg(skf_pkg::REG_Q_OFF_AND_R,
                {small_q(512), 32'($urandom_range(1, 32'h0004_0000))});
      write_reg(skf_pkg::REG_P_INIT_DIAG, {32'($urandom_range(0, 32'h000a_0000)),
                                           32'($urandom_range(0, 32'h000a_0000))});
      write_reg(skf_pkg::REG_P_INIT_OFF, {32'd0, small_q(4096)});
      write_reg(skf_pkg::REG_X_INIT, {small_q(32'h0010_0000), small_q(32'h0001_0000)});
    end
  endtask

  // Result side: random stall bursts, check on each transfer.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        board.check(out_ch.estimate_first, out_ch.estimate_second, out_ch.gain_fault);
      if (out_ch.valid && out_ch.ready && out_ch.gain_fault) faults++;
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 17);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    board = new();
    cycles = 0;
    sent = 0; faults = 0; restarts = 0;
    calm = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.measurement = '0; in_ch.restart = 1'b0;
    f0_reg = skf_pkg::RST_F_ROW0; f1_reg = skf_pkg::RST_F_ROW1;
    h_reg = skf_pkg::RST_H_ROW; qd_reg = skf_pkg::RST_Q_DIAG;
    qr_reg = skf_pkg::RST_Q_OFF_AND_R; pd_reg = skf_pkg::RST_P_INIT_DIAG;
    po_reg = skf_pkg::RST_P_INIT_OFF; x0_reg = skf_pkg::RST_X_INIT;
    sv = '{0, 0};
    cov = '{0, 0, 0, 0};
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset defaults, field extremes, restart both ways.
    send(32'sh0001_0000, 1'b0);
    send(32'sh7fffffff, 1'b0);
    send(32'sh80000000, 1'b1);
    send(0, 1'b0);
    send(-1, 1'b1);
    send(32'sh5555_aaaa, 1'b0);
    drain();
    // Zero R and zero covariance give a non-positive innovation variance.
    write_reg(skf_pkg::REG_Q_OFF_AND_R, 64'd0);
    write_reg(skf_pkg::REG_P_INIT_DIAG, 64'd0);
    send(32'sh0002_0000, 1'b1);
    send(32'sh0003_0000, 1'b0);
    drain();
    // Negative R forces the fault path outright.
    write_reg(skf_pkg::REG_Q_OFF_AND_R, {32'h0000_0100, 32'h8000_0000});
    send(32'sh0001_0000, 1'b0);
    drain();
    // Extreme matrices drive the intermediates into saturation.
    for (int i = 0; i < 8; i++) write_reg(i[2:0], 64'h7fffffff_7fffffff);
    send(32'sh7fffffff, 1'b1);
    send(32'sh80000000, 1'b0);
    drain();
    for (int i = 0; i < 8; i++) write_reg(i[2:0], 64'h80000000_80000000);
    send(32'sh80000000, 1'b1);
    send(32'sh7fffffff, 1'b0);
    drain();
    for (int i = 0; i < 8; i++) write_reg(i[2:0], 64'hffffffff_ffffffff);
    send(-1, 1'b1);
    send(32'sh2aaa_5555, 1'b0);
    drain();
    // Tiny positive S drives the gain quotient into saturation.
    write_reg(skf_pkg::REG_F_ROW0, 64'h00010000_00000000);
    write_reg(skf_pkg::REG_F_ROW1, 64'h00000000_00010000);
    write_reg(skf_pkg::REG_H_ROW, 64'h00000001_00000000);
    write_reg(skf_pkg::REG_Q_OFF_AND_R, 64'h00000000_00000001);
    write_reg(skf_pkg::REG_P_INIT_DIAG, 64'h7fff0000_7fff0000);
    write_reg(skf_pkg::REG_P_INIT_OFF, 64'h00000000_80000000);
    write_reg(skf_pkg::REG_X_INIT, 64'h80000000_7fffffff);
    send(32'sh7fffffff, 1'b1);
    send(32'sh80000000, 1'b0);
    drain();

    // Random phases: mostly tracking runs with sane settings, some wild ones.
    for (int ph = 0; ph < 34; ph++) begin
      random_setting(ph % 6 == 5);
      if (ph == 33) calm = 1;
      for (int n = 0; n < 50; n++) begin
        if (n == 25 && ph % 4 == 0) drain();
        send($urandom_range(0, 3) == 0 ? rand_word() : small_q(32'h0020_0000),
             n == 0 || $urandom_range(0, 15) == 0);
      end
      drain();
    end

    $display("covered %0d measurements, %0d restarts, %0d faulted steps, %0d checked",
             sent, restarts, faults, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("scalar_kalman_filter_unit_tb passed");
    end else begin
      $display("%0d mismatches, %0d left over", board.errors, board.pending.size());
      $display("scalar_kalman_filter_unit_tb failed");
    end
    $finish;
  end

endmodule
